[rtl/core/step_pulse_target_queue_macros.svh]
// Assertion macros shared by the step pulse target queue RTL.
`ifndef STEP_PULSE_TARGET_QUEUE_MACROS_SVH
`define STEP_PULSE_TARGET_QUEUE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SPT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/spt_pkg.sv]
`timescale 1ns / 1ps
package spt_pkg;

    // Target queue sizing
    localparam int QUEUE_DEPTH = 3;
    localparam int Q_CNT_W = ($clog2(QUEUE_DEPTH + 1) > 2) ? $clog2(QUEUE_DEPTH + 1) : 2;
    localparam int Q_IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Configuration register map
    localparam int APB_ADDR_W = 3;
    localparam logic REG_HOMING_TRAVEL = 1'b0;
    localparam logic signed [15:0] HOMING_TRAVEL_RST = 16'sd3000;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_PUSH = 2'd1,
        CMD_GOTO = 2'd2,
        CMD_HOME = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd               command;
        logic signed [15:0] target;
        logic [9:0]         home_sensor;
    } t_item;

    typedef struct packed {
        logic               pin_forward;
        logic               pin_reverse;
        logic               busy_res;
        logic signed [15:0] position;
        logic [1:0]         queue_count;
        logic               push_dropped;
    } t_result;

    typedef struct packed {
        logic               push;
        logic               pop;
        logic signed [15:0] wdata;
    } t_q_req;

endpackage

[rtl/core/spt_queue.sv]
`timescale 1ns / 1ps
module spt_queue
    import spt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_q_req             i_req,
    output logic signed [15:0] o_head,
    output logic [Q_CNT_W-1:0] o_count
);

    logic signed [15:0] r_entry [QUEUE_DEPTH];
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_CNT_W-1:0] n_count;

    // Track fill level; push and pop never land on the same beat
    always_comb begin
        n_count = r_count;
        if (i_req.push) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (i_req.pop) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Write at the tail, shift toward the head on pop
    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            r_entry[r_count[Q_IDX_W-1:0]] <= i_req.wdata;
        end else if (i_req.pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                r_entry[i] <= r_entry[i + 1];
            end
        end
    end

    assign o_head  = r_entry[0];
    assign o_count = r_count;

endmodule

[rtl/core/spt_motor.sv]
`timescale 1ns / 1ps
module spt_motor
    import spt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  t_item              i_item,
    input  logic signed [15:0] i_homing_travel,
    input  logic signed [15:0] i_q_head,
    input  logic [Q_CNT_W-1:0] i_q_count,
    output t_q_req             o_q_req,
    output t_result            o_result
);

    logic signed [15:0] r_pos, n_pos;
    logic signed [15:0] r_goal, n_goal;
    logic               r_rev, n_rev;
    logic               r_phase, n_phase;
    logic [1:0]         r_tcnt, n_tcnt;
    logic               r_busy, n_busy;
    logic               r_homed, n_homed;
    logic               r_fwd, n_fwd;
    logic               r_rvl, n_rvl;

    logic signed [15:0] step_pos;
    logic [1:0]         step_tcnt;
    logic               dropped;
    logic [Q_CNT_W-1:0] n_qcnt;

    // Next state for one beat
    always_comb begin
        n_pos   = r_pos;
        n_goal  = r_goal;
        n_rev   = r_rev;
        n_phase = r_phase;
        n_tcnt  = r_tcnt;
        n_busy  = r_busy;
        n_homed = r_homed;
        n_fwd   = r_fwd;
        n_rvl   = r_rvl;
        dropped = 1'b0;
        o_q_req = '{push: 1'b0, pop: 1'b0, wdata: i_item.target};

        // apply a pending step once three toggles are done
        step_pos  = r_pos;
        step_tcnt = r_tcnt;
        if (r_tcnt == 2'd3) begin
            step_pos  = r_rev ? r_pos - 16'sd1 : r_pos + 16'sd1;
            step_tcnt = 2'd0;
        end

        case (i_item.command)
            CMD_TICK: begin
                if (!r_homed && i_item.home_sensor == '0) begin
                    n_homed = 1'b1;
                    n_pos   = '0;
                    n_goal  = '0;
                    n_phase = 1'b0;
                    n_tcnt  = 2'd0;
                    n_busy  = 1'b0;
                end else begin
                    n_pos = step_pos;
                    if (step_pos == r_goal) begin
                        // at target: idle or pop the next goal
                        n_busy = 1'b0;
                        n_tcnt = 2'd0;
                        if (i_q_count != '0) begin
                            o_q_req.pop = 1'b1;
                            n_goal = i_q_head;
                            n_rev  = i_q_head < step_pos;
                            n_busy = 1'b1;
                        end
                    end else begin
                        // toggle the pin of the current direction
                        if (r_rev) begin
                            n_rvl = ~r_phase;
                        end else begin
                            n_fwd = ~r_phase;
                        end
                        n_phase = ~r_phase;
                        n_tcnt  = step_tcnt + 2'd1;
                    end
                end
            end
            CMD_PUSH: begin
                if (i_q_count >= Q_CNT_W'(QUEUE_DEPTH)) begin
                    dropped = 1'b1;
                end else begin
                    o_q_req.push = 1'b1;
                end
            end
            CMD_GOTO: begin
                n_goal = i_item.target;
                n_rev  = i_item.target < r_pos;
                n_busy = 1'b1;
            end
            default: begin
                n_homed = 1'b0;
                n_busy  = 1'b1;
                n_goal  = i_homing_travel;
                n_rev   = i_homing_travel < r_pos;
            end
        endcase

        // gate queue requests by the beat strobe
        o_q_req.push = o_q_req.push & i_fire;
        o_q_req.pop  = o_q_req.pop & i_fire;

        n_qcnt = i_q_count;
        if (o_q_req.push) begin
            n_qcnt = i_q_count + Q_CNT_W'(1);
        end else if (o_q_req.pop) begin
            n_qcnt = i_q_count - Q_CNT_W'(1);
        end

        o_result.pin_forward  = n_fwd;
        o_result.pin_reverse  = n_rvl;
        o_result.busy_res     = n_busy;
        o_result.position     = n_pos;
        o_result.queue_count  = (n_qcnt > Q_CNT_W'(3)) ? 2'd3 : n_qcnt[1:0];
        o_result.push_dropped = dropped;
    end

    // Commit state only on a processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_goal  <= '0;
            r_rev   <= 1'b0;
            r_phase <= 1'b0;
            r_tcnt  <= 2'd0;
            r_busy  <= 1'b0;
            r_homed <= 1'b1;
            r_fwd   <= 1'b0;
            r_rvl   <= 1'b0;
        end else if (i_fire) begin
            r_pos   <= n_pos;
            r_goal  <= n_goal;
            r_rev   <= n_rev;
            r_phase <= n_phase;
            r_tcnt  <= n_tcnt;
            r_busy  <= n_busy;
            r_homed <= n_homed;
            r_fwd   <= n_fwd;
            r_rvl   <= n_rvl;
        end
    end

endmodule

[rtl/core/step_pulse_target_queue.sv]
`timescale 1ns / 1ps
// Step pulse generator for a two-pin motor drive with a queue of targets.
// Input channel (i_valid / o_stall) carries one command beat: tick, push
// target, go to target, or start homing. Output channel (o_valid / i_stall)
// returns exactly one result beat per command: pin levels, busy, position,
// queue fill and a push-dropped flag.
// A beat accepted into the input register is processed as it moves into the
// result register, and shows on the output from then on. Throughput: one
// beat per cycle while the receiver does not stall; the input register, the
// single-pass step logic and the result register form a two-deep pipe.
// A receiver stall holds the result register; the step logic then waits with
// the item parked in the input register, and o_stall rises only once that
// register is full and cannot drain.
// Reset (synchronous, active low) empties both registers and the queue,
// clears position and goal, and reloads homing_travel to 3000.
// The APB port at address 0 holds homing_travel; pready is always high and
// writes are meant to land only while the block is idle.
module step_pulse_target_queue
    import spt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_command,
    input  logic signed [15:0]    i_target,
    input  logic [9:0]            i_home_sensor,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_pin_forward,
    output logic                  o_pin_reverse,
    output logic                  o_busy_res,
    output logic signed [15:0]    o_position,
    output logic [1:0]            o_queue_count,
    output logic                  o_push_dropped,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

`include "step_pulse_target_queue_macros.svh"

    logic               r_in_valid;
    t_item              r_item;
    logic               r_out_valid;
    t_result            r_result;
    logic signed [15:0] r_homing_travel;

    logic               advance;
    logic               in_take;
    t_q_req             q_req;
    logic signed [15:0] q_head;
    logic [Q_CNT_W-1:0] q_count;
    t_result            step_result;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = {{16{r_homing_travel[15]}}, r_homing_travel};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_homing_travel <= HOMING_TRAVEL_RST;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_HOMING_TRAVEL) begin
            r_homing_travel <= pwdata[15:0];
        end
    end

    // Pipe control
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= '{command: t_cmd'(i_command), target: i_target,
                        home_sensor: i_home_sensor};
        end
    end

    spt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (q_req),
        .o_head  (q_head),
        .o_count (q_count)
    );

    spt_motor u_motor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (advance),
        .i_item          (r_item),
        .i_homing_travel (r_homing_travel),
        .i_q_head        (q_head),
        .i_q_count       (q_count),
        .o_q_req         (q_req),
        .o_result        (step_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= step_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pin_forward  = r_result.pin_forward;
    assign o_pin_reverse  = r_result.pin_reverse;
    assign o_busy_res     = r_result.busy_res;
    assign o_position     = r_result.position;
    assign o_queue_count  = r_result.queue_count;
    assign o_push_dropped = r_result.push_dropped;

    // Checks
    `SPT_ASSERT_IMP(a_no_stall_when_empty, !r_out_valid, !o_stall, "stall with empty result register")
    `SPT_ASSERT_NXT(a_drop_only_on_push, advance && r_item.command != CMD_PUSH, !r_result.push_dropped, "drop flag on non-push beat")
    `SPT_ASSERT_NXT(a_push_grows_queue, q_req.push, q_count == $past(q_count) + Q_CNT_W'(1), "queue did not grow on push")

endmodule
